@@ design/small_matrix_add_sub_mul_defines.svh @@
// Assertion macros for the small matrix add/sub/mul block.
// Included by smas_seq, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef SMALL_MATRIX_ADD_SUB_MUL_DEFINES_SVH
`define SMALL_MATRIX_ADD_SUB_MUL_DEFINES_SVH
`ifndef SYNTH
`define SMAS_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smas assertion failed");
`define SMAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smas assertion failed");
`else
`define SMAS_ASSERT(label, clk, rst, ante, cons)
`define SMAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/smas_pkg.sv @@
// Shared constants, types and helper functions of the small matrix add/sub/mul block.
// No dependencies; every other file of the block but the assertion macro header imports it.
package smas_pkg;

   localparam int MAX_DIM    = 8;
   localparam int ELEM_WIDTH = 32;
   localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int IDX_W      = 3;
   localparam int DIM_W      = 4;
   localparam int MODE_W     = 2;
   localparam int OPC_W      = 2;
   localparam int VAL_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   // transaction opcodes
   localparam logic [OPC_W-1:0] OPC_WRITE_A = 2'd0;
   localparam logic [OPC_W-1:0] OPC_WRITE_B = 2'd1;
   localparam logic [OPC_W-1:0] OPC_COMPUTE = 2'd2;

   // operation modes
   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd4;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      ALU_PASS,
      ALU_ADD,
      ALU_SUB,
      ALU_MAC
   } alu_op_type;

   typedef struct packed {
      logic [DIM_W-1:0]  a_rows;
      logic [DIM_W-1:0]  a_cols;
      logic [DIM_W-1:0]  b_rows;
      logic [DIM_W-1:0]  b_cols;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic              en_a;
      logic              en_b;
      logic [ADDR_W-1:0] addr;
   } store_wr_type;

   // zero counts as one, anything above the store size as the store size
   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (int'(d) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   function automatic elem_type from_in(input logic signed [VAL_W-1:0] v);
      logic signed [ELEM_WIDTH+VAL_W-1:0] wide;
      wide = (ELEM_WIDTH + VAL_W)'(v);
      return wide[ELEM_WIDTH-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] to_out(input elem_type e);
      logic signed [ELEM_WIDTH+VAL_W-1:0] wide;
      wide = (ELEM_WIDTH + VAL_W)'(signed'(e));
      return wide[VAL_W-1:0];
   endfunction

endpackage

@@ design/smas_req_if.sv @@
// Request channel of the small matrix add/sub/mul block: valid/ready plus request fields.
// Depends on smas_pkg for field widths.
interface smas_req_if;
   import smas_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, opcode, row_index, col_index, value, input ready);
   modport sink   (input valid, opcode, row_index, col_index, value, output ready);
endinterface

@@ design/smas_rsp_if.sv @@
// Response channel of the small matrix add/sub/mul block: valid/ready plus result fields.
// Depends on smas_pkg for field widths.
interface smas_rsp_if;
   import smas_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [VAL_W-1:0] out_value;
   logic                    last;
   logic                    dim_error;

   modport source (output valid, out_row, out_col, out_value, last, dim_error, input ready);
   modport sink   (input valid, out_row, out_col, out_value, last, dim_error, output ready);
endinterface

@@ design/smas_store.sv @@
// Element stores for matrices A and B: one write port each, registered read data.
// Depends on smas_pkg.
module smas_store (
   input  logic                          clock,
   input  smas_pkg::store_wr_type        wr,
   input  smas_pkg::elem_type            wr_data,
   input  logic [smas_pkg::ADDR_W-1:0]   rd_addr_a,
   input  logic [smas_pkg::ADDR_W-1:0]   rd_addr_b,
   output smas_pkg::elem_type            rd_a,
   output smas_pkg::elem_type            rd_b
);
   import smas_pkg::*;

   elem_type mem_a_ff [MEM_DEPTH];
   elem_type mem_b_ff [MEM_DEPTH];
   elem_type rd_a_ff;
   elem_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en_a) begin
         mem_a_ff[wr.addr] <= wr_data;
      end
      rd_a_ff <= mem_a_ff[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr.en_b) begin
         mem_b_ff[wr.addr] <= wr_data;
      end
      rd_b_ff <= mem_b_ff[rd_addr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
endmodule

@@ design/smas_alu.sv @@
// Shared arithmetic unit: add, subtract, pass or multiply-accumulate over store read data.
// Depends on smas_pkg; control tags follow the store read latency.
module smas_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  smas_pkg::alu_ctl_type ctl,
   input  smas_pkg::elem_type    rd_a,
   input  smas_pkg::elem_type    rd_b,
   output smas_pkg::elem_type    acc,
   output logic                  done
);
   import smas_pkg::*;

   alu_ctl_type ctl0_ff;
   alu_ctl_type ctl1_ff;
   elem_type    prod_ff, prod_in;
   elem_type    sum_ff, sum_in;
   elem_type    acc_ff, acc_in;
   logic        done_ff;

   // stage 1: one multiplier and one adder over the read data
   always_comb begin
      prod_in = rd_a * rd_b;
      unique case (ctl0_ff.op)
         ALU_ADD: sum_in = rd_a + rd_b;
         ALU_SUB: sum_in = rd_a - rd_b;
         default: sum_in = rd_a;
      endcase
   end

   // stage 2: accumulate or take the sum
   always_comb begin
      acc_in = acc_ff;
      if (ctl1_ff.valid) begin
         if (ctl1_ff.op == ALU_MAC) begin
            acc_in = (ctl1_ff.first ? '0 : acc_ff) + prod_ff;
         end else begin
            acc_in = sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
         ctl1_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl0_ff <= ctl;
         ctl1_ff <= ctl0_ff;
         done_ff <= ctl1_ff.valid && ctl1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl0_ff.valid) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;
endmodule

@@ design/smas_seq.sv @@
// Sequencer: takes request transactions, walks the result matrix and drives the response register.
// Depends on smas_pkg, the channel interfaces and the assertion macro header.
`include "small_matrix_add_sub_mul_defines.svh"
module smas_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  smas_pkg::cfg_type             cfg,
   smas_req_if.sink                      req_chan,
   smas_rsp_if.source                    rsp_chan,
   output smas_pkg::store_wr_type        wr,
   output smas_pkg::elem_type            wr_data,
   output logic [smas_pkg::ADDR_W-1:0]   rd_addr_a,
   output logic [smas_pkg::ADDR_W-1:0]   rd_addr_b,
   output smas_pkg::alu_ctl_type         alu_ctl,
   input  smas_pkg::elem_type            alu_acc,
   input  logic                          alu_done
);
   import smas_pkg::*;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic                    valid_ff, valid_in;
   logic [IDX_W-1:0]        orow_ff, orow_in;
   logic [IDX_W-1:0]        ocol_ff, ocol_in;
   logic signed [VAL_W-1:0] oval_ff, oval_in;
   logic                    last_ff, last_in;
   logic                    err_ff, err_in;

   logic [DIM_W-1:0] ar, ac, br, bc, col_lim, k_lim;
   logic             is_addsub, is_mul, mul_ok, pass_mode, single_err;
   logic             row_last, col_last, k_last, in_range;
   alu_op_type       op;

   always_comb begin
      ar = dim_clamp(cfg.a_rows);
      ac = dim_clamp(cfg.a_cols);
      br = dim_clamp(cfg.b_rows);
      bc = dim_clamp(cfg.b_cols);
      is_addsub  = (cfg.mode == MODE_ADD) || (cfg.mode == MODE_SUB);
      is_mul     = (cfg.mode == MODE_MUL);
      mul_ok     = is_mul && (ac == br);
      pass_mode  = is_mul && (ac != br);
      single_err = (is_addsub && ((ar != br) || (ac != bc))) || !(is_addsub || is_mul);
      col_lim    = mul_ok ? bc : ac;
      k_lim      = mul_ok ? ac : DIM_W'(1);
      row_last   = (DIM_W'(row_ff) + DIM_W'(1)) == ar;
      col_last   = (DIM_W'(col_ff) + DIM_W'(1)) == col_lim;
      k_last     = (DIM_W'(k_ff) + DIM_W'(1)) == k_lim;
      if (mul_ok) begin
         op = ALU_MAC;
      end else if (pass_mode) begin
         op = ALU_PASS;
      end else if (cfg.mode == MODE_SUB) begin
         op = ALU_SUB;
      end else begin
         op = ALU_ADD;
      end
      in_range = (int'(req_chan.row_index) < MAX_DIM) && (int'(req_chan.col_index) < MAX_DIM);
   end

   assign rd_addr_a = elem_addr(row_ff, mul_ok ? k_ff : col_ff);
   assign rd_addr_b = mul_ok ? elem_addr(k_ff, col_ff) : elem_addr(row_ff, col_ff);
   assign wr_data   = from_in(req_chan.value);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      oval_in  = oval_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      alu_ctl  = '0;
      wr.en_a  = 1'b0;
      wr.en_b  = 1'b0;
      wr.addr  = elem_addr(req_chan.row_index, req_chan.col_index);
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               unique case (req_chan.opcode)
                  OPC_WRITE_A: wr.en_a = in_range;
                  OPC_WRITE_B: wr.en_b = in_range;
                  OPC_COMPUTE: begin
                     row_in = '0;
                     col_in = '0;
                     k_in   = '0;
                     if (single_err) begin
                        valid_in = 1'b1;
                        orow_in  = '0;
                        ocol_in  = '0;
                        oval_in  = '0;
                        last_in  = 1'b1;
                        err_in   = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_ISSUE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            // one read pair per cycle into the shared unit
            alu_ctl.valid = 1'b1;
            alu_ctl.first = (k_ff == '0);
            alu_ctl.last  = k_last;
            alu_ctl.op    = op;
            if (k_last) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (alu_done) begin
               valid_in = 1'b1;
               orow_in  = row_ff;
               ocol_in  = col_ff;
               oval_in  = to_out(alu_acc);
               last_in  = row_last && col_last;
               err_in   = pass_mode;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + IDX_W'(1);
                  end else begin
                     col_in = col_ff + IDX_W'(1);
                  end
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      orow_ff <= orow_in;
      ocol_ff <= ocol_in;
      oval_ff <= oval_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_row   = orow_ff;
   assign rsp_chan.out_col   = ocol_ff;
   assign rsp_chan.out_value = oval_ff;
   assign rsp_chan.last      = last_ff;
   assign rsp_chan.dim_error = err_ff;

   `SMAS_ASSERT(a_no_req_while_rsp, clock, reset, valid_ff, !req_chan.ready)
   `SMAS_ASSERT_NEXT(a_last_returns_idle, clock, reset, valid_ff && rsp_chan.ready && last_ff, state_ff == ST_IDLE)
   `SMAS_ASSERT(a_done_only_in_drain, clock, reset, alu_done, state_ff == ST_DRAIN)
endmodule

@@ design/small_matrix_add_sub_mul.sv @@
// Top level of the small matrix add/sub/mul block: configuration registers and unit wiring.
// Depends on smas_pkg, smas_req_if, smas_rsp_if, smas_store, smas_alu and smas_seq.
//
// Usage:
//   req_chan carries transactions: write an element of A, write an element of B,
//   or compute. Writes produce no response. A compute
//   transaction emits the result matrix on rsp_chan in row-major order, with
//   last set on the final element and dim_error set when the dimensions do not
//   suit the operation (mode from the csr_ port: add, subtract or multiply).
//   Add, subtract and the flagged copy of A: each result element takes one
//   read, a two-stage arithmetic pass and the output register. Multiply: each
//   element takes a_cols reads, set by the single read port per store feeding
//   one shared multiply-accumulate, which takes one operand pair per cycle. A single
//   flagged zero comes out in the cycle after its compute transaction is taken.
//   req_chan.ready is high only while no compute is in progress.
//   A stalled rsp_chan holds the result register and the whole sequencer.
//   Reset clears the sequencer and sets all dimensions to 1 and mode to add;
//   the element stores are not cleared and must be written before use.
//   Write the csr_ registers only while the block is idle.
module small_matrix_add_sub_mul (
   input  logic                              clock,
   input  logic                              reset,
   smas_req_if.sink                          req_chan,
   smas_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [smas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smas_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import smas_pkg::*;

   cfg_type cfg_ff, cfg_in;

   store_wr_type      wr;
   elem_type          wr_data;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   elem_type          rd_a, rd_b;
   alu_ctl_type       alu_ctl;
   elem_type          alu_acc;
   logic              alu_done;

   // register writes: ignore indexes beyond the register list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_A_ROWS: cfg_in.a_rows = csr_write_data[DIM_W-1:0];
            CSR_A_COLS: cfg_in.a_cols = csr_write_data[DIM_W-1:0];
            CSR_B_ROWS: cfg_in.b_rows = csr_write_data[DIM_W-1:0];
            CSR_B_COLS: cfg_in.b_cols = csr_write_data[DIM_W-1:0];
            CSR_MODE:   cfg_in.mode   = csr_write_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_rows <= DIM_W'(1);
         cfg_ff.a_cols <= DIM_W'(1);
         cfg_ff.b_rows <= DIM_W'(1);
         cfg_ff.b_cols <= DIM_W'(1);
         cfg_ff.mode   <= MODE_ADD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: walks rows, columns and the inner index
   smas_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .wr        (wr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .alu_ctl   (alu_ctl),
      .alu_acc   (alu_acc),
      .alu_done  (alu_done)
   );

   // element stores for A and B
   smas_store u_store (
      .clock     (clock),
      .wr        (wr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   // shared add/subtract/multiply-accumulate unit
   smas_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .rd_a  (rd_a),
      .rd_b  (rd_b),
      .acc   (alu_acc),
      .done  (alu_done)
   );
endmodule
